@@ sv/gcm_pkg.sv @@
`timescale 1ns / 1ps

package gcm_pkg;

  localparam int DefMaxDenoms  = 6;
  localparam int DefAmountBits = 24;

  localparam int AmountW   = 24;
  localparam int CoinW     = 16;
  localparam int CountW    = 24;
  localparam int LeftW     = 16;
  localparam int DenomCntW = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegDenomCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoinFirst  = 3'd1;

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SORT_EVEN,
    OP_SORT_ODD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT_COIN,
    OP_SHIFT,
    OP_EMIT_SUM
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CNT_MORE,
    COND_DEN_DONE,
    COND_SKIP,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic in_rdy;
  } ctl_t;

  typedef struct packed {
    logic cnt_more;
    logic den_done;
    logic skip;
    logic out_busy;
  } stat_t;

  localparam pc_t StepWait     = 4'd0;
  localparam pc_t StepSortEven = 4'd1;
  localparam pc_t StepSortOdd  = 4'd2;
  localparam pc_t StepTest     = 4'd3;
  localparam pc_t StepDivInit  = 4'd4;
  localparam pc_t StepDivStep  = 4'd5;
  localparam pc_t StepCoin     = 4'd6;
  localparam pc_t StepShift    = 4'd7;
  localparam pc_t StepSum      = 4'd8;
  localparam pc_t StepDone     = 4'd9;

endpackage

@@ sv/gcm_seq.sv @@
`timescale 1ns / 1ps

module gcm_seq import gcm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  pc_t    pc_q, pc_d;
  ucode_t word;
  logic   take;
  logic   hold;

  always_comb begin
    unique case (pc_q)
      StepWait:     word = '{op: OP_ACCEPT,    cond: COND_NO_INPUT, target: StepWait};
      StepSortEven: word = '{op: OP_SORT_EVEN, cond: COND_NEVER,    target: StepWait};
      StepSortOdd:  word = '{op: OP_SORT_ODD,  cond: COND_CNT_MORE, target: StepSortEven};
      StepTest:     word = '{op: OP_NOP,       cond: COND_DEN_DONE, target: StepSum};
      StepDivInit:  word = '{op: OP_DIV_INIT,  cond: COND_SKIP,     target: StepShift};
      StepDivStep:  word = '{op: OP_DIV_STEP,  cond: COND_CNT_MORE, target: StepDivStep};
      StepCoin:     word = '{op: OP_EMIT_COIN, cond: COND_OUT_BUSY, target: StepCoin};
      StepShift:    word = '{op: OP_SHIFT,     cond: COND_ALWAYS,   target: StepTest};
      StepSum:      word = '{op: OP_EMIT_SUM,  cond: COND_OUT_BUSY, target: StepSum};
      StepDone:     word = '{op: OP_NOP,       cond: COND_ALWAYS,   target: StepWait};
      default:      word = '{op: OP_NOP,       cond: COND_ALWAYS,   target: StepWait};
    endcase
  end

  always_comb begin
    unique case (word.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !in_valid_i;
      COND_CNT_MORE: take = stat_i.cnt_more;
      COND_DEN_DONE: take = stat_i.den_done;
      COND_SKIP:     take = stat_i.skip;
      COND_OUT_BUSY: take = stat_i.out_busy;
      default:       take = 1'b0;
    endcase
  end

  // A step that waits on a handshake does nothing until the transfer can happen.
  assign hold = take && (word.cond == COND_NO_INPUT || word.cond == COND_OUT_BUSY);
  assign pc_d = take ? word.target : pc_q + 4'd1;

  assign ctl_o.op     = hold ? OP_NOP : word.op;
  assign ctl_o.in_rdy = (word.op == OP_ACCEPT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ sv/gcm_div.sv @@
`timescale 1ns / 1ps

module gcm_div import gcm_pkg::*; #(
  parameter int RemW = DefAmountBits
) (
  input  logic             clk_i,
  input  logic             init_i,
  input  logic             step_i,
  input  logic [RemW-1:0]  dividend_i,
  input  logic [CoinW-1:0] divisor_i,
  output logic [RemW-1:0]  quot_o,
  output logic [CoinW-1:0] rem_o
);

  logic [CoinW-1:0] p_q, p_d;
  logic [RemW-1:0]  dq_q, dq_d;
  logic [CoinW:0]   trial;
  logic [CoinW:0]   diff;
  logic             ge;

  assign trial = {p_q, dq_q[RemW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    p_d  = p_q;
    dq_d = dq_q;
    if (init_i) begin
      p_d  = '0;
      dq_d = dividend_i;
    end else if (step_i) begin
      p_d  = ge ? diff[CoinW-1:0] : trial[CoinW-1:0];
      dq_d = {dq_q[RemW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    dq_q <= dq_d;
  end

  assign quot_o = dq_q;
  assign rem_o  = p_q;

endmodule

@@ sv/gcm_datapath.sv @@
`timescale 1ns / 1ps

module gcm_datapath import gcm_pkg::*; #(
  parameter int MaxDenoms = DefMaxDenoms,
  parameter int RemW      = DefAmountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [AmountW-1:0]  amount_i,
  input  ctl_t                ctl_i,
  output stat_t               stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                item_kind_o,
  output logic [CoinW-1:0]    coin_value_o,
  output logic [CountW-1:0]   coin_count_o,
  output logic [LeftW-1:0]    leftover_o,
  output logic                payable_o,
  output logic                last_item_o
);

  localparam int CntW      = $clog2(RemW + 1);
  localparam int DenW      = $clog2(MaxDenoms + 1);
  localparam int SortIters = (MaxDenoms + 1) / 2;
  localparam int CmpW      = (RemW > CoinW) ? RemW : CoinW;

  logic [DenomCntW-1:0] denom_count_q;
  logic [CoinW-1:0]     coin_q [MaxDenoms];
  logic [CoinW-1:0]     w_q    [MaxDenoms];
  logic [CoinW-1:0]     w_d    [MaxDenoms];
  logic [CoinW-1:0]     w_even [MaxDenoms];
  logic [CoinW-1:0]     w_odd  [MaxDenoms];
  logic [RemW-1:0]      rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DenW-1:0]      den_q, den_d;
  logic                 out_valid_q, out_valid_d;
  logic                 emit;
  logic                 out_busy;
  logic [RemW-1:0]      quot;
  logic [CoinW-1:0]     div_rem;
  logic [CmpW-1:0]      rem_ext;
  logic [LeftW-1:0]     left_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      denom_count_q <= DenomCntW'(1);
      for (int i = 0; i < MaxDenoms; i++) begin
        coin_q[i] <= CoinW'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegDenomCount) begin
        denom_count_q <= cfg_wdata_i[DenomCntW-1:0];
      end
      for (int i = 0; i < MaxDenoms; i++) begin
        if (cfg_idx_i == RegCoinFirst + CfgIdxW'(i)) begin
          coin_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  always_comb begin
    w_even = w_q;
    for (int k = 0; k + 1 < MaxDenoms; k += 2) begin
      if (w_q[k] < w_q[k+1]) begin
        w_even[k]   = w_q[k+1];
        w_even[k+1] = w_q[k];
      end
    end
    w_odd = w_q;
    for (int k = 1; k + 1 < MaxDenoms; k += 2) begin
      if (w_q[k] < w_q[k+1]) begin
        w_odd[k]   = w_q[k+1];
        w_odd[k+1] = w_q[k];
      end
    end
  end

  always_comb begin
    w_d   = w_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    den_d = den_q;
    case (ctl_i.op)
      OP_ACCEPT: begin
        for (int i = 0; i < MaxDenoms; i++) begin
          w_d[i] = (DenomCntW'(i) < denom_count_q) ? coin_q[i] : '0;
        end
        rem_d = amount_i[RemW-1:0];
        cnt_d = CntW'(SortIters);
        den_d = DenW'(MaxDenoms);
      end
      OP_SORT_EVEN: w_d = w_even;
      OP_SORT_ODD: begin
        w_d   = w_odd;
        cnt_d = cnt_q - CntW'(1);
      end
      OP_DIV_INIT: cnt_d = CntW'(RemW);
      OP_DIV_STEP: cnt_d = cnt_q - CntW'(1);
      OP_EMIT_COIN: rem_d = RemW'(div_rem);
      OP_SHIFT: begin
        for (int i = 0; i + 1 < MaxDenoms; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[MaxDenoms-1] = '0;
        den_d = den_q - DenW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    den_q <= den_d;
  end

  gcm_div #(
    .RemW(RemW)
  ) u_div (
    .clk_i      (clk_i),
    .init_i     (ctl_i.op == OP_DIV_INIT),
    .step_i     (ctl_i.op == OP_DIV_STEP),
    .dividend_i (rem_q),
    .divisor_i  (w_q[0]),
    .quot_o     (quot),
    .rem_o      (div_rem)
  );

  assign rem_ext  = CmpW'(rem_q);
  assign left_sat = (rem_ext > CmpW'({LeftW{1'b1}})) ? {LeftW{1'b1}} : rem_ext[LeftW-1:0];

  assign out_busy    = out_valid_q && out_stall_i;
  assign emit        = (ctl_i.op == OP_EMIT_COIN) || (ctl_i.op == OP_EMIT_SUM);
  assign out_valid_d = emit || out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_EMIT_COIN) begin
      item_kind_o  <= 1'b0;
      coin_value_o <= w_q[0];
      coin_count_o <= CountW'(quot);
      leftover_o   <= '0;
      payable_o    <= 1'b0;
      last_item_o  <= 1'b0;
    end else if (ctl_i.op == OP_EMIT_SUM) begin
      item_kind_o  <= 1'b1;
      coin_value_o <= '0;
      coin_count_o <= '0;
      leftover_o   <= left_sat;
      payable_o    <= (rem_q == '0);
      last_item_o  <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.cnt_more = (cnt_q != CntW'(1));
  assign stat_o.den_done = (den_q == '0);
  assign stat_o.skip     = (w_q[0] == '0) || (CmpW'(w_q[0]) > rem_ext);
  assign stat_o.out_busy = out_busy;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == OP_DIV_STEP |-> w_q[0] != '0)
    else $error("Division step runs with a zero divisor.");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == OP_EMIT_COIN |-> div_rem < w_q[0])
    else $error("Remainder is not below the denomination on a coin line.");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("Emitted result is not presented.");

  a_den_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == OP_SHIFT |-> den_q != '0)
    else $error("Denomination counter underflows.");
`endif

endmodule

@@ sv/greedy_change_maker_unit.sv @@
`timescale 1ns / 1ps

// Greedy coin change. Each amount transferred on the input channel is paid out
// from up to MAX_DENOMS configured denominations, largest first. Every usable
// denomination produces one coin line with its coin count, and a summary item
// with last_item_o set closes the sequence for that amount.
// The configuration port is to be written only while the block is idle; the
// block itself does not enforce this. Index 0 is the denomination count,
// indexes 1 to 6 are the denomination values. A microcoded sequencer drives
// a sort network and a restoring divider that produces one quotient bit per
// cycle. An amount is loaded and sorted, then each denomination is either
// skipped or divided over W quotient bits (W is AMOUNT_BITS, at most 24),
// and the summary follows. One amount is processed at a time; the next is
// accepted after the summary is loaded into the output register.
// Reset returns the sequencer to its wait step, empties the output register
// and sets the count and all denominations to 1. When the receiver stalls,
// the pending result holds and the sequencer waits at its next emit step.
module greedy_change_maker_unit import gcm_pkg::*; #(
  parameter int MAX_DENOMS  = DefMaxDenoms,
  parameter int AMOUNT_BITS = DefAmountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [AmountW-1:0]  amount_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                item_kind_o,
  output logic [CoinW-1:0]    coin_value_o,
  output logic [CountW-1:0]   coin_count_o,
  output logic [LeftW-1:0]    leftover_o,
  output logic                payable_o,
  output logic                last_item_o
);

  localparam int RemW = (AMOUNT_BITS < AmountW) ? AMOUNT_BITS : AmountW;

  ctl_t  ctl;
  stat_t stat;

  gcm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  gcm_datapath #(
    .MaxDenoms (MAX_DENOMS),
    .RemW      (RemW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .amount_i     (amount_i),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .item_kind_o  (item_kind_o),
    .coin_value_o (coin_value_o),
    .coin_count_o (coin_count_o),
    .leftover_o   (leftover_o),
    .payable_o    (payable_o),
    .last_item_o  (last_item_o)
  );

  assign in_stall_o = !ctl.in_rdy;

endmodule

@@ tb/greedy_change_maker_unit_test.sv @@
`timescale 1ns / 1ps

module greedy_change_maker_unit_test;
  import gcm_pkg::*;

  localparam int MaxDenoms = DefMaxDenoms;
  localparam int SettleCycles = 200;
  localparam longint TimeoutNs = 12_000_000;
  localparam logic [CfgIdxW-1:0] RegUnknown = 3'd7;
  localparam logic KindCoin = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CoinW-1:0]  value;
    logic [CountW-1:0] count;
    logic [LeftW-1:0]  left;
    logic              pay;
    logic              last;
  } pay_line_t;

  class change_book;
    logic [DenomCntW-1:0] denom_cnt;
    logic [CoinW-1:0]     coin_reg [MaxDenoms];
    pay_line_t            due_lines [$];
    int                   fault_cnt;

    function new();
      denom_cnt = 1;
      foreach (coin_reg[i]) coin_reg[i] = 1;
      fault_cnt = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegDenomCount) begin
        denom_cnt = data[DenomCntW-1:0];
      end else if (int'(idx) >= int'(RegCoinFirst) &&
                   int'(idx) < int'(RegCoinFirst) + MaxDenoms) begin
        coin_reg[int'(idx) - int'(RegCoinFirst)] = data;
      end
    endfunction

    // Sorts the denominations in use largest first and pays the amount out.
    function void note_amount(logic [AmountW-1:0] amount);
      int unsigned order [MaxDenoms];
      int unsigned rem;
      int unsigned d;
      int          used;
      int          i;
      int          j;
      pay_line_t   line;
      used = (int'(denom_cnt) > MaxDenoms) ? MaxDenoms : int'(denom_cnt);
      for (i = 0; i < used; i++) begin
        d = coin_reg[i];
        j = i;
        while (j > 0 && order[j-1] < d) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = d;
      end
      rem = amount;
      for (i = 0; i < used; i++) begin
        if (order[i] != 0 && order[i] <= rem) begin
          line = '0;
          line.kind = KindCoin;
          line.value = CoinW'(order[i]);
          line.count = CountW'(rem / order[i]);
          rem = rem % order[i];
          due_lines.push_back(line);
        end
      end
      line = '0;
      line.kind = KindSummary;
      line.left = (rem > 32'hFFFF) ? 16'hFFFF : LeftW'(rem);
      line.pay = (rem == 0);
      line.last = 1'b1;
      due_lines.push_back(line);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        fault_cnt++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_line(pay_line_t got);
      pay_line_t want;
      if (due_lines.size() == 0) begin
        fault_cnt++;
        $display("%0t: result with none expected, actual kind %0d value %0d count %0d",
                 $time, got.kind, got.value, got.count);
        return;
      end
      want = due_lines.pop_front();
      compare_field("item_kind", want.kind, got.kind);
      compare_field("coin_value", want.value, got.value);
      compare_field("coin_count", want.count, got.count);
      compare_field("leftover", want.left, got.left);
      compare_field("payable", want.pay, got.pay);
      compare_field("last_item", want.last, got.last);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [AmountW-1:0]  amount_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                item_kind_o;
  logic [CoinW-1:0]    coin_value_o;
  logic [CountW-1:0]   coin_count_o;
  logic [LeftW-1:0]    leftover_o;
  logic                payable_o;
  logic                last_item_o;

  change_book book;
  bit idle_on = 1'b1;
  int hold_request = 0;

  greedy_change_maker_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .amount_i     (amount_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_kind_o  (item_kind_o),
    .coin_value_o (coin_value_o),
    .coin_count_o (coin_count_o),
    .leftover_o   (leftover_o),
    .payable_o    (payable_o),
    .last_item_o  (last_item_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #(TimeoutNs);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int span;
    forever begin
      if (hold_request > 0) begin
        span = hold_request;
        hold_request = 0;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
      end else begin
        span = idle_on ? $urandom_range(1, 18) : 1;
        out_stall_i <= 1'b0;
      end
      repeat (span) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      book.check_line({item_kind_o, coin_value_o, coin_count_o, leftover_o, payable_o,
                       last_item_o});
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.set_reg(idx, data);
  endtask

  task automatic load_config(input logic [CfgDataW-1:0] cnt, v0, v1, v2, v3, v4, v5);
    logic [CfgDataW-1:0] vals [MaxDenoms];
    int i;
    vals = '{v0, v1, v2, v3, v4, v5};
    write_reg(RegDenomCount, cnt);
    for (i = 0; i < MaxDenoms; i++) write_reg(RegCoinFirst + CfgIdxW'(i), vals[i]);
  endtask

  // The amount is noted only once its transfer has happened.
  task automatic send_amount(input logic [AmountW-1:0] amount, input bit may_gap);
    if (may_gap && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    amount_i <= amount;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    book.note_amount(amount);
  endtask

  task automatic send_random(input int n, input bit may_gap);
    logic [AmountW-1:0] amount;
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: amount = '0;
        1: amount = '1;
        2, 3, 4: amount = AmountW'($urandom_range(0, 1000));
        5, 6: amount = AmountW'($urandom_range(0, 200000));
        default: amount = AmountW'($urandom());
      endcase
      send_amount(amount, may_gap);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (book.due_lines.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    int i;
    int pick;
    int cnt;
    logic [CfgDataW-1:0] coin;
    book = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegDenomCount;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    amount_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_amount('0, 1'b1);
    send_amount(24'd1, 1'b1);
    send_amount('1, 1'b1);
    send_amount(24'd5, 1'b1);
    wait_drained();

    load_config(16'd4, 16'd10, 16'd1, 16'd25, 16'd5, 16'd3, 16'd40000);
    send_amount('0, 1'b1);
    send_amount(24'd99, 1'b1);
    send_amount(24'd41, 1'b1);
    send_amount('1, 1'b1);
    send_amount(24'd3, 1'b1);
    wait_drained();

    load_config(16'd6, 16'hFFFF, 16'd0, 16'd7, 16'd7, 16'hFFFF, 16'd1);
    send_amount(24'd65535, 1'b1);
    send_amount(24'd65534, 1'b1);
    send_amount('1, 1'b1);
    send_amount(24'd131071, 1'b1);
    send_amount(24'd6, 1'b1);
    wait_drained();

    write_reg(RegDenomCount, 16'd0);
    send_amount('1, 1'b1);
    send_amount(24'd100, 1'b1);
    send_amount('0, 1'b1);
    wait_drained();

    write_reg(RegUnknown, 16'd5);
    write_reg(RegDenomCount, 16'hFFFF);
    send_amount('1, 1'b1);
    send_amount(24'd20, 1'b1);
    send_amount('0, 1'b1);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      pick = $urandom_range(0, 9);
      cnt = (pick == 8) ? 0 : (pick == 9) ? 7 : $urandom_range(1, 6);
      write_reg(RegDenomCount, CfgDataW'(($urandom() & 32'hFFF8) | cnt));
      coin = 16'd1;
      for (i = 0; i < MaxDenoms; i++) begin
        case ($urandom_range(0, 9))
          0: coin = '0;
          1: coin = '1;
          2, 3: coin = CfgDataW'($urandom_range(1, 20));
          4, 5: coin = CfgDataW'($urandom_range(1, 1000));
          6: ;
          default: coin = CfgDataW'($urandom_range(1, 65535));
        endcase
        write_reg(RegCoinFirst + CfgIdxW'(i), coin);
      end
      if ($urandom_range(0, 3) == 0) write_reg(RegUnknown, CfgDataW'($urandom()));
      if (phase == 2) begin
        hold_request = 400;
        send_random(12, 1'b0);
        send_random(33, 1'b1);
      end else if (phase == 5) begin
        send_random(20, 1'b1);
        wait_drained();
        send_random(25, 1'b1);
      end else begin
        send_random(45, 1'b1);
      end
      wait_drained();
    end

    idle_on = 1'b0;
    send_random(40, 1'b0);
    wait_drained();

    if (book.fault_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gcm_pkg.sv
sv/gcm_seq.sv
sv/gcm_div.sv
sv/gcm_datapath.sv
sv/greedy_change_maker_unit.sv
tb/greedy_change_maker_unit_test.sv
